>>> rtl/brb_pkg.sv
`timescale 1ns / 1ps
// Package for the overwriting byte ring buffer: command codes, field widths
// and the input and result item structs. No dependencies.
package brb_pkg;

  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int AMOUNT_W = 8;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BYTE_W-1:0]   push_byte;
    logic [AMOUNT_W-1:0] amount;
  } brb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               byte_valid;
    logic               last;
    logic [COUNT_W-1:0] done_count;
    logic [COUNT_W-1:0] occupancy;
    logic               overwrote;
  } brb_out_t;

endpackage

>>> rtl/byte_ring_buffer_overwrite_core.sv
`timescale 1ns / 1ps
// Top level of the overwriting byte ring buffer: index control, byte store,
// shared modular index adder and result register. Depends on brb_pkg.

// A push, a remove, an empty read or an unused command gives its single
// result in the cycle after acceptance. A read that returns n bytes (n is the
// requested amount clamped to the occupancy) starts the registered read of the
// store in the accept cycle, then loads one byte per cycle into the result
// register, paced by the single read port of the store and by the consumer
// taking results. The block accepts no new item while a read run is in
// progress. Index arithmetic for push, remove and the read walk all goes
// through one shared add-and-wrap unit. Writing the capacity register empties
// the buffer; the store itself is never cleared, and only entries written
// since the buffer was last emptied are ever returned.
module byte_ring_buffer_overwrite_core
  import brb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  brb_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output brb_out_t           out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Architectural state.
  logic [COUNT_W-1:0] capacity;
  logic [IDX_W-1:0]   write_index;
  logic [IDX_W-1:0]   read_index;
  logic               is_full;

  // Sequencer and read-run state.
  logic               state;
  logic [IDX_W-1:0]   walk_index;
  logic [CNT_W-1:0]   remaining;
  logic [CNT_W-1:0]   run_count;
  logic [CNT_W-1:0]   run_occ;

  // Byte store with a registered read port.
  logic [BYTE_W-1:0]  store [DEPTH];
  logic [IDX_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]  rd_data;

  logic [CNT_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   occ;
  logic [CNT_W-1:0]   clamp_n;
  logic               out_free;
  logic               in_fire;
  logic               step_read;

  // Shared add-and-wrap unit.
  logic [IDX_W-1:0]   add_a;
  logic [CNT_W-1:0]   add_b;
  logic [CNT_W:0]     add_sum;
  logic [IDX_W-1:0]   add_idx;

  logic               push_full_next;

  // A capacity of zero behaves as one, anything above DEPTH as DEPTH.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity > COUNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = capacity[CNT_W-1:0];
    end
  end

  // Occupancy from the indices and the full flag.
  always_comb begin
    if (is_full) begin
      occ = cap_eff;
    end else if (write_index >= read_index) begin
      occ = CNT_W'(write_index) - CNT_W'(read_index);
    end else begin
      occ = cap_eff - (CNT_W'(read_index) - CNT_W'(write_index));
    end
  end

  // Read and remove amounts are clamped to what is held.
  assign clamp_n = (in_data.amount < AMOUNT_W'(occ)) ? in_data.amount[CNT_W-1:0] : occ;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign step_read = (state == ST_READ) && out_free;

  // The adder walks the read run one entry at a time, advances the write
  // index on a push and moves the read index by the clamped count on a remove.
  // Its operands stay below twice the capacity, so one subtract wraps them.
  always_comb begin
    if (state == ST_READ) begin
      add_a = walk_index;
      add_b = CNT_W'(1);
    end else if (in_data.cmd == CMD_REMOVE) begin
      add_a = read_index;
      add_b = clamp_n;
    end else begin
      add_a = write_index;
      add_b = CNT_W'(1);
    end
    add_sum = (CNT_W + 1)'(add_a) + (CNT_W + 1)'(add_b);
    if (add_sum >= (CNT_W + 1)'(cap_eff)) begin
      add_sum = add_sum - (CNT_W + 1)'(cap_eff);
    end
    add_idx = add_sum[IDX_W-1:0];
  end

  assign push_full_next = is_full || (add_idx == read_index);

  // The address runs one entry ahead of the result register during a run.
  always_comb begin
    if (state == ST_READ) begin
      rd_addr = step_read ? add_idx : walk_index;
    end else begin
      rd_addr = read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.cmd == CMD_PUSH)) begin
      store[write_index] <= in_data.push_byte;
    end
    rd_data <= store[rd_addr];
  end

  // Index state, capacity and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAPACITY_RESET;
      write_index <= '0;
      read_index  <= '0;
      is_full     <= 1'b0;
      state       <= ST_IDLE;
    end else if (cfg_wr_en) begin
      capacity    <= cfg_wr_data;
      write_index <= '0;
      read_index  <= '0;
      is_full     <= 1'b0;
      state       <= ST_IDLE;
    end else if (in_fire) begin
      case (in_data.cmd)
        CMD_PUSH: begin
          write_index <= add_idx;
          is_full     <= push_full_next;
          if (push_full_next) begin
            read_index <= add_idx;
          end
        end
        CMD_READ: begin
          if (clamp_n != '0) begin
            state <= ST_READ;
          end
        end
        CMD_REMOVE: begin
          read_index <= add_idx;
          if (clamp_n != '0) begin
            is_full <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (step_read && (remaining == CNT_W'(1))) begin
      state <= ST_IDLE;
    end
  end

  // Read-run bookkeeping; no reset needed, it is loaded when a run starts.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      walk_index <= read_index;
      remaining  <= clamp_n;
      run_count  <= clamp_n;
      run_occ    <= occ;
    end else if (step_read) begin
      walk_index <= add_idx;
      remaining  <= remaining - CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= !((in_data.cmd == CMD_READ) && (clamp_n != '0));
    end else if (step_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.read_byte  <= '0;
      out_data.byte_valid <= 1'b0;
      out_data.last       <= 1'b1;
      out_data.overwrote  <= 1'b0;
      case (in_data.cmd)
        CMD_PUSH: begin
          out_data.done_count <= COUNT_W'(1);
          out_data.occupancy  <= push_full_next ? COUNT_W'(cap_eff)
                                                : COUNT_W'(occ) + COUNT_W'(1);
          out_data.overwrote  <= is_full;
        end
        CMD_READ: begin
          out_data.done_count <= '0;
          out_data.occupancy  <= COUNT_W'(occ);
        end
        CMD_REMOVE: begin
          out_data.done_count <= COUNT_W'(clamp_n);
          out_data.occupancy  <= COUNT_W'(occ - clamp_n);
        end
        default: begin
          out_data.done_count <= '0;
          out_data.occupancy  <= COUNT_W'(occ);
        end
      endcase
    end else if (step_read) begin
      out_data.read_byte  <= rd_data;
      out_data.byte_valid <= 1'b1;
      out_data.last       <= (remaining == CNT_W'(1));
      out_data.done_count <= COUNT_W'(run_count);
      out_data.occupancy  <= COUNT_W'(run_occ);
      out_data.overwrote  <= 1'b0;
    end
  end

endmodule
